// File: sv/lru_cache_hit_cost_counter_defines.svh
// Assertion macros for the LRU cache hit cost counter.
// Included by the modules that carry assertions; expects clk and rst in scope.
`ifndef LRU_CACHE_HIT_COST_COUNTER_DEFINES_SVH
`define LRU_CACHE_HIT_COST_COUNTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define LCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/lcc_pkg.sv
// Shared types and constants for the LRU cache hit cost counter.
// No dependencies; used by every module of the block.
`default_nettype none

package lcc_pkg;

  localparam int KEY_BITS      = 64;
  localparam int WAYS_BITS     = 6;
  localparam int COST_BITS     = 32;
  localparam int DEF_CAPACITY  = 32;
  localparam int DEF_KEY_WIDTH = 64;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [WAYS_BITS-1:0] WAYS_RESET = WAYS_BITS'(32);
  localparam logic [COST_BITS-1:0] HIT_COST   = COST_BITS'(1);
  localparam logic [COST_BITS-1:0] MISS_COST  = COST_BITS'(5);
  localparam logic [COST_BITS-1:0] COST_MAX   = {COST_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lcc_state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                no_ways;
  } lcc_beat_t;

endpackage

`default_nettype wire

// File: sv/lru_cache_hit_cost_counter.sv
// Top level of the LRU cache hit cost counter: config register, front end,
// queue and lookup engine. Depends on lcc_pkg, lcc_front, lcc_queue, lcc_back.
//
// Channel   Signals                         Beat
// input     in_valid / in_ready             lookup_key
// output    out_valid / out_ready           hit, total_cost
// config    cfg_we                          cfg_data (ways_in_use)
//
// An item's time in the engine is set by the scan of min(ways_in_use, CAPACITY)
// entries of the key memory through its single read port; zero ways skips the scan.
// The front end keeps taking beats into a two-entry queue while the engine works.
// A finished result sits in the output register; the engine stalls only in its
// final step while that register is full and out_ready is low.
// Synchronous reset clears valid bits, ranks, cost total, state, queue and out_valid.
`default_nettype none

module lru_cache_hit_cost_counter #(
  parameter int CAPACITY  = lcc_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = lcc_pkg::DEF_KEY_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [lcc_pkg::WAYS_BITS-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lcc_pkg::KEY_BITS-1:0]   lookup_key,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                hit,
  output logic [lcc_pkg::COST_BITS-1:0]       total_cost
);

  logic [lcc_pkg::WAYS_BITS-1:0] ways_in_use;
  logic                          push;
  lcc_pkg::lcc_beat_t            push_beat;
  logic                          q_full;
  logic                          q_pop;
  lcc_pkg::lcc_beat_t            pop_beat;
  logic                          q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= lcc_pkg::WAYS_RESET;
    end else if (cfg_we) begin
      ways_in_use <= cfg_data;
    end
  end

  lcc_front #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .lookup_key  (lookup_key),
    .ways_in_use (ways_in_use),
    .push        (push),
    .push_beat   (push_beat),
    .q_full      (q_full)
  );

  lcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .full      (q_full),
    .pop       (q_pop),
    .pop_beat  (pop_beat),
    .not_empty (q_valid)
  );

  lcc_back #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .ways_in_use (ways_in_use),
    .q_valid     (q_valid),
    .q_beat      (pop_beat),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .total_cost  (total_cost)
  );

endmodule

`default_nettype wire

// File: sv/lcc_front.sv
// Front end: takes input beats, masks the key and flags the zero-ways case.
// Depends on lcc_pkg; feeds lcc_queue.
`default_nettype none

module lcc_front #(
  parameter int KEY_WIDTH = lcc_pkg::DEF_KEY_WIDTH
) (
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lcc_pkg::KEY_BITS-1:0]   lookup_key,
  input  wire logic [lcc_pkg::WAYS_BITS-1:0]  ways_in_use,
  output logic                                push,
  output lcc_pkg::lcc_beat_t                  push_beat,
  input  wire logic                           q_full
);

  localparam logic [lcc_pkg::KEY_BITS-1:0] KEY_MASK =
    {lcc_pkg::KEY_BITS{1'b1}} >> (lcc_pkg::KEY_BITS - KEY_WIDTH);

  always_comb begin
    in_ready          = !q_full;
    push              = in_valid && !q_full;
    push_beat.key     = lookup_key & KEY_MASK;
    push_beat.no_ways = (ways_in_use == '0);
  end

endmodule

`default_nettype wire

// File: sv/lcc_queue.sv
// Short FIFO between the front end and the lookup engine.
// Depends on lcc_pkg for the beat type and depth.
`default_nettype none

module lcc_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire lcc_pkg::lcc_beat_t push_beat,
  output logic                    full,
  input  wire logic               pop,
  output lcc_pkg::lcc_beat_t      pop_beat,
  output logic                    not_empty
);

  localparam int PW = (lcc_pkg::QUEUE_DEPTH > 1) ? $clog2(lcc_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(lcc_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(lcc_pkg::QUEUE_DEPTH - 1);

  lcc_pkg::lcc_beat_t slots [lcc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_comb begin
    full      = (count == CW'(lcc_pkg::QUEUE_DEPTH));
    not_empty = (count != '0);
    pop_beat  = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/lcc_back.sv
// Lookup engine: scans the key memory (if ways_in_use is nonzero), picks hit,
// empty slot or LRU victim, ages ranks, writes a missed key, registers result.
// Depends on lcc_pkg and lru_cache_hit_cost_counter_defines.svh.
`default_nettype none
`include "lru_cache_hit_cost_counter_defines.svh"

module lcc_back #(
  parameter int CAPACITY  = lcc_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = lcc_pkg::DEF_KEY_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [lcc_pkg::WAYS_BITS-1:0]  ways_in_use,
  input  wire logic                           q_valid,
  input  wire lcc_pkg::lcc_beat_t             q_beat,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                hit,
  output logic [lcc_pkg::COST_BITS-1:0]       total_cost
);

  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int UW0 = $clog2(CAPACITY + 1);
  localparam int W   = (UW0 > lcc_pkg::WAYS_BITS) ? UW0 : lcc_pkg::WAYS_BITS;
  localparam logic [IW-1:0] RANK_MAX = IW'(CAPACITY - 1);

  lcc_pkg::lcc_state_t state;
  lcc_pkg::lcc_state_t state_next;

  logic [KEY_WIDTH-1:0] keys [CAPACITY];
  logic [KEY_WIDTH-1:0] rd_key;
  logic [CAPACITY-1:0]  valid;
  logic [IW-1:0]        rank [CAPACITY];

  logic [KEY_WIDTH-1:0] key_q;
  logic                 no_ways;
  logic [W-1:0]         used_q;
  logic [W-1:0]         used_now;
  logic [W-1:0]         idx;
  logic                 pend;
  logic [IW-1:0]        pidx;
  logic                 hit_f;
  logic [IW-1:0]        hit_pos;
  logic [IW-1:0]        hit_rank;
  logic                 empty_f;
  logic [IW-1:0]        empty_pos;
  logic [IW-1:0]        vic_pos;
  logic [IW-1:0]        vic_rank;
  logic [lcc_pkg::COST_BITS-1:0] cost_sum;

  logic                 issue;
  logic                 fire;
  logic                 do_age;
  logic                 do_fill;
  logic                 age_all;
  logic [IW-1:0]        sel_pos;
  logic [IW-1:0]        below;
  logic [lcc_pkg::COST_BITS-1:0] add;
  logic [lcc_pkg::COST_BITS-1:0] cost_next;

  always_comb begin
    used_now = (W'(ways_in_use) > W'(CAPACITY)) ? W'(CAPACITY) : W'(ways_in_use);
    issue    = (state == lcc_pkg::ST_SCAN) && (idx < used_q);
    fire     = (state == lcc_pkg::ST_UPDATE) && (!out_valid || out_ready);
    q_pop    = (state == lcc_pkg::ST_IDLE) && q_valid;
    do_fill  = !hit_f && !no_ways;
    do_age   = hit_f || !no_ways;
    if (hit_f) begin
      sel_pos = hit_pos;
      age_all = 1'b0;
      below   = hit_rank;
    end else if (empty_f) begin
      sel_pos = empty_pos;
      age_all = 1'b1;
      below   = vic_rank;
    end else begin
      sel_pos = vic_pos;
      age_all = 1'b0;
      below   = vic_rank;
    end
    add       = hit_f ? lcc_pkg::HIT_COST : lcc_pkg::MISS_COST;
    cost_next = (cost_sum > (lcc_pkg::COST_MAX - add)) ? lcc_pkg::COST_MAX : cost_sum + add;

    state_next = state;
    case (state)
      lcc_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = q_beat.no_ways ? lcc_pkg::ST_UPDATE : lcc_pkg::ST_SCAN;
        end
      end
      lcc_pkg::ST_SCAN: begin
        if (!issue && !pend) begin
          state_next = lcc_pkg::ST_UPDATE;
        end
      end
      lcc_pkg::ST_UPDATE: begin
        if (fire) begin
          state_next = lcc_pkg::ST_IDLE;
        end
      end
      default: state_next = lcc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_key <= keys[idx[IW-1:0]];
    end
    if (fire && do_fill) begin
      keys[sel_pos] <= key_q;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (q_pop) begin
      key_q     <= q_beat.key[KEY_WIDTH-1:0];
      no_ways   <= q_beat.no_ways;
      used_q    <= used_now;
      idx       <= '0;
      hit_f     <= 1'b0;
      empty_f   <= 1'b0;
      vic_pos   <= '0;
      vic_rank  <= '0;
    end else begin
      if (issue) begin
        idx <= idx + W'(1);
      end
      if (pend) begin
        if (valid[pidx] && (rd_key == key_q) && !hit_f) begin
          hit_f    <= 1'b1;
          hit_pos  <= pidx;
          hit_rank <= rank[pidx];
        end
        if (!valid[pidx] && !empty_f) begin
          empty_f   <= 1'b1;
          empty_pos <= pidx;
        end
        if (rank[pidx] > vic_rank) begin
          vic_pos  <= pidx;
          vic_rank <= rank[pidx];
        end
      end
    end
    pidx <= idx[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= issue;
    end
  end

  // valid bits and recency ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank[i] <= '0;
      end
    end else if (fire && do_age) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if ((W'(i) < used_q) && valid[i] && (age_all || (rank[i] < below))
            && (rank[i] != RANK_MAX)) begin
          rank[i] <= rank[i] + IW'(1);
        end
        if (IW'(i) == sel_pos) begin
          rank[i] <= '0;
        end
      end
      if (do_fill) begin
        valid[sel_pos] <= 1'b1;
      end
    end
  end

  // cost total and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cost_sum  <= '0;
      out_valid <= 1'b0;
    end else if (fire) begin
      cost_sum  <= cost_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hit        <= hit_f;
      total_cost <= cost_next;
    end
  end

  `LCC_ASSERT_IMP(a_scan_in_range, pend, W'(pidx) < used_q, "scan read beyond ways in use")
  `LCC_ASSERT_IMP(a_cost_monotonic, !$past(rst), cost_sum >= $past(cost_sum), "cost total fell")
  `LCC_ASSERT_IMP(a_result_from_update, $rose(out_valid), $past(state) == lcc_pkg::ST_UPDATE, "result without update")

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for lru_cache_hit_cost_counter: random bursty lookups
// against an in-bench LRU mirror, across several ways_in_use settings.
// Depends on lcc_pkg and the lru_cache_hit_cost_counter RTL only.
`timescale 1ns / 100ps

module testbench;

  localparam int SLOTS        = 32;
  localparam int HOLDOFF      = 48;
  localparam int LIMIT_CYCLES = 400000;
  localparam int POOL_SIZE    = 40;

  typedef struct {
    logic                          hit;
    logic [lcc_pkg::COST_BITS-1:0] cost;
  } lookup_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [lcc_pkg::WAYS_BITS-1:0] cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [lcc_pkg::KEY_BITS-1:0]  lookup_key = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          hit;
  logic [lcc_pkg::COST_BITS-1:0] total_cost;

  lru_cache_hit_cost_counter u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .lookup_key (lookup_key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .total_cost (total_cost)
  );

  always #5 clk = ~clk;

  logic [lcc_pkg::KEY_BITS-1:0]  mirror_keys [SLOTS];
  logic                          mirror_valid [SLOTS];
  logic [4:0]                    mirror_rank [SLOTS];
  logic [lcc_pkg::COST_BITS-1:0] mirror_cost = '0;
  logic [lcc_pkg::WAYS_BITS-1:0] mirror_ways = lcc_pkg::WAYS_RESET;

  logic [lcc_pkg::KEY_BITS-1:0]  key_backlog[$];
  lookup_result_t                expected_lookups[$];
  logic [lcc_pkg::KEY_BITS-1:0]  key_pool [POOL_SIZE];

  int   errors = 0;
  int   cycles = 0;
  int   n_lookups = 0;
  int   n_hits = 0;
  int   n_settings = 0;
  logic in_fire = 1'b0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      mirror_keys[i]  = '0;
      mirror_valid[i] = 1'b0;
      mirror_rank[i]  = '0;
    end
  end

  function automatic void age_ranks(int used, bit all, logic [4:0] below);
    for (int i = 0; i < used; i++)
      if (mirror_valid[i] && (all || mirror_rank[i] < below) && mirror_rank[i] != 5'd31)
        mirror_rank[i]++;
  endfunction

  function automatic void add_cost(logic [lcc_pkg::COST_BITS-1:0] c);
    mirror_cost = (mirror_cost > lcc_pkg::COST_MAX - c) ? lcc_pkg::COST_MAX : mirror_cost + c;
  endfunction

  function automatic lookup_result_t predict_lookup(logic [lcc_pkg::KEY_BITS-1:0] key);
    int             used;
    int             pos;
    bit             found;
    bit             empty_found;
    lookup_result_t r;
    used  = (mirror_ways > SLOTS) ? SLOTS : int'(mirror_ways);
    found = 1'b0;
    pos   = 0;
    for (int i = 0; i < used; i++)
      if (!found && mirror_valid[i] && mirror_keys[i] == key) begin
        found = 1'b1;
        pos   = i;
      end
    if (found) begin
      age_ranks(used, 1'b0, mirror_rank[pos]);
      mirror_rank[pos] = '0;
      add_cost(lcc_pkg::HIT_COST);
    end else begin
      if (used > 0) begin
        empty_found = 1'b0;
        for (int i = 0; i < used; i++)
          if (!empty_found && !mirror_valid[i]) begin
            empty_found = 1'b1;
            pos         = i;
          end
        if (empty_found) begin
          age_ranks(used, 1'b1, '0);
        end else begin
          pos = 0;
          for (int i = 1; i < used; i++)
            if (mirror_rank[i] > mirror_rank[pos]) pos = i;
          age_ranks(used, 1'b0, mirror_rank[pos]);
        end
        mirror_keys[pos]  = key;
        mirror_valid[pos] = 1'b1;
        mirror_rank[pos]  = '0;
      end
      add_cost(lcc_pkg::MISS_COST);
    end
    r.hit  = found;
    r.cost = mirror_cost;
    return r;
  endfunction

  // check results, then record accepted lookups
  always @(posedge clk) begin
    lookup_result_t exp_r;
    in_fire <= in_valid && in_ready && !rst;
    if (!rst && out_valid && out_ready) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result beat hit=%0b total_cost=%0d", $time, hit, total_cost);
        errors++;
      end else begin
        exp_r = expected_lookups.pop_front();
        n_lookups++;
        if (exp_r.hit) n_hits++;
        if (hit !== exp_r.hit) begin
          $display("%0t: hit mismatch: expected %0b, got %0b", $time, exp_r.hit, hit);
          errors++;
        end
        if (total_cost !== exp_r.cost) begin
          $display("%0t: total_cost mismatch: expected %0d, got %0d",
                   $time, exp_r.cost, total_cost);
          errors++;
        end
      end
    end
    if (!rst && in_valid && in_ready)
      expected_lookups.push_back(predict_lookup(lookup_key));
  end

  // sender: bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    int r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold the beat
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (key_backlog.size() > 0) begin
      in_valid   <= 1'b1;
      lookup_key <= key_backlog.pop_front();
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        r = $urandom_range(0, 9);
        if (r < 4) gap_left = 0;
        else if (r < 8) gap_left = $urandom_range(1, 6);
        else gap_left = $urandom_range(10, 50);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: out_ready follows a stall pattern, refreshed once fully shifted out
  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_left = 0;
  always @(negedge clk) begin
    int mode;
    if (pattern_left == 0) begin
      mode = $urandom_range(0, 3);
      case (mode)
        0, 1: ready_pattern = 16'hFFFF;
        2: ready_pattern = 16'($urandom_range(0, 16'hFFFF));
        default: ready_pattern = 16'h8000;
      endcase
      pattern_left = 16;
    end
    out_ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    pattern_left--;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_lookups.size());
      $display("** lru_cache_hit_cost_counter: FAILED **");
      $finish;
    end
  end

  task automatic wait_drained();
    while (key_backlog.size() != 0 || in_valid || expected_lookups.size() != 0)
      @(posedge clk);
  endtask

  task automatic program_ways(logic [lcc_pkg::WAYS_BITS-1:0] ways);
    wait_drained();
    repeat (HOLDOFF) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= ways;
    mirror_ways = ways;
    n_settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [lcc_pkg::KEY_BITS-1:0] pick_key(int window);
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, window - 1)];
  endfunction

  localparam logic [lcc_pkg::KEY_BITS-1:0] KEY_ONES = {lcc_pkg::KEY_BITS{1'b1}};
  localparam logic [lcc_pkg::KEY_BITS-1:0] KEY_A5   = 64'hA5A5_A5A5_A5A5_A5A5;
  localparam logic [lcc_pkg::KEY_BITS-1:0] KEY_5A   = 64'h5A5A_5A5A_5A5A_5A5A;

  initial begin
    logic [lcc_pkg::WAYS_BITS-1:0] ways_plan [12];
    int eff;
    int window;
    ways_plan = '{6'd32, 6'd1, 6'd5, 6'd17, 6'd0, 6'd33, 6'd8, 6'd31, 6'd63, 6'd3, 6'd2,
                  6'd32};
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill and hit at the reset setting, then evict in a two-way cache
    key_backlog = '{'0, KEY_ONES, '0, KEY_ONES, KEY_A5, KEY_5A};
    program_ways(6'd2);
    key_backlog = '{KEY_A5, '0, KEY_ONES, KEY_A5};
    // every access misses, entries untouched
    program_ways(6'd0);
    key_backlog = '{'0, KEY_ONES, KEY_A5};
    // oversized setting, hidden entries come back with equal ranks
    program_ways(6'd63);
    key_backlog = '{KEY_5A, KEY_A5, '0, KEY_ONES, KEY_5A};

    foreach (ways_plan[p]) begin
      program_ways(ways_plan[p]);
      eff    = (ways_plan[p] > SLOTS) ? SLOTS : int'(ways_plan[p]);
      window = eff + $urandom_range(0, 6);
      if (window < 2) window = 2;
      if (window > POOL_SIZE) window = POOL_SIZE;
      repeat (34) key_backlog.push_back(pick_key(window));
    end

    wait_drained();
    repeat (HOLDOFF) @(posedge clk);
    if (expected_lookups.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_lookups.size());
      errors++;
    end
    $display("checked %0d lookups (%0d hits) over %0d ways_in_use settings, %0d cycles",
             n_lookups, n_hits, n_settings, cycles);
    if (errors == 0) begin
      $display("** lru_cache_hit_cost_counter: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** lru_cache_hit_cost_counter: FAILED **");
    end
    $finish;
  end

endmodule
